### design/ffr_pkg.sv
`timescale 1ns / 1ps

package ffr_pkg;

  localparam int unsigned MAX_BANDS_DEF     = 256;
  localparam int unsigned MAX_COLUMNS_DEF   = 1024;
  localparam int unsigned MAX_REF_LINES_DEF = 1023;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned BAND_W    = 8;
  localparam int unsigned COLUMN_W  = 10;
  localparam int unsigned LINES_W   = 10;
  localparam int unsigned SUM_W     = 26;
  localparam int unsigned AVG_W     = 24;
  localparam int unsigned REFL_W    = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LINES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LINES  = 8'd1;

  typedef enum logic [1:0] {
    ACT_WHITE = 2'd0,
    ACT_DARK  = 2'd1,
    ACT_IMAGE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    action_e               kind;
    logic                  ok;
    logic [SAMPLE_W-1:0]   sample;
  } item_t;

  typedef struct packed {
    logic [LINES_W-1:0] white;
    logic [LINES_W-1:0] dark;
  } lines_t;

endpackage

### design/ffr_ram.sv
`timescale 1ns / 1ps

module ffr_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffr_fifo.sv
`timescale 1ns / 1ps

module ffr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ffr_pkg::FIFO_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

### design/ffr_front.sv
`timescale 1ns / 1ps

module ffr_front #(
  parameter int unsigned MAX_BANDS     = ffr_pkg::MAX_BANDS_DEF,
  parameter int unsigned MAX_COLUMNS   = ffr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_REF_LINES = ffr_pkg::MAX_REF_LINES_DEF,
  localparam int unsigned DEPTH = MAX_BANDS * MAX_COLUMNS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       action_i,
  input  logic [ffr_pkg::BAND_W-1:0]       band_i,
  input  logic [ffr_pkg::COLUMN_W-1:0]     column_i,
  input  logic [ffr_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ffr_pkg::LINES_W-1:0]      cfg_data_i,
  input  logic                             busy_i,
  input  logic                             fifo_full_i,
  output logic                             push_o,
  output logic [AW+$bits(ffr_pkg::item_t)-1:0] push_data_o,
  output ffr_pkg::lines_t                  lines_o
);

  logic [ffr_pkg::LINES_W-1:0] white_lines_q, dark_lines_q;
  ffr_pkg::action_e            kind;
  ffr_pkg::item_t              item;
  logic [AW-1:0]               idx;
  logic                        in_range;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_i && !fifo_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_lines_q <= ffr_pkg::LINES_W'(1);
      dark_lines_q  <= ffr_pkg::LINES_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ffr_pkg::CFG_WHITE_LINES) begin
        white_lines_q <= cfg_data_i;
      end else if (cfg_index_i == ffr_pkg::CFG_DARK_LINES) begin
        dark_lines_q <= cfg_data_i;
      end
    end
  end

  assign lines_o.white = (32'(white_lines_q) > 32'(MAX_REF_LINES))
                         ? ffr_pkg::LINES_W'(MAX_REF_LINES) : white_lines_q;
  assign lines_o.dark  = (32'(dark_lines_q) > 32'(MAX_REF_LINES))
                         ? ffr_pkg::LINES_W'(MAX_REF_LINES) : dark_lines_q;

  assign kind     = ffr_pkg::action_e'(action_i);
  assign in_range = (32'(band_i) < 32'(MAX_BANDS)) && (32'(column_i) < 32'(MAX_COLUMNS));
  assign idx      = in_range ? AW'(32'(band_i) * 32'(MAX_COLUMNS) + 32'(column_i)) : '0;

  assign item.kind   = kind;
  assign item.ok     = in_range;
  assign item.sample = sample_i;

  assign push_o      = in_valid_i && in_ready_o && (kind != ffr_pkg::ACT_NONE);
  assign push_data_o = {idx, item};

endmodule

### design/ffr_div.sv
`timescale 1ns / 1ps

module ffr_div #(
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q  [QW];
  logic [DW-1:0] r_q  [QW];
  logic [QW-1:0] lo_q [QW];
  logic [QW-1:0] qt_q [QW];
  logic [DW-1:0] d_q  [QW];
  logic [SW-1:0] s_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_in;
    logic [DW-1:0] r_in, d_in;
    logic [QW-1:0] lo_in, q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   t, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in  = vld_i;
      assign r_in  = rem_i;
      assign lo_in = low_i;
      assign q_in  = '0;
      assign d_in  = den_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign lo_in = lo_q[k-1];
      assign q_in  = qt_q[k-1];
      assign d_in  = d_q[k-1];
      assign s_in  = s_q[k-1];
    end

    assign t    = {r_in, lo_in[QW-1]};
    assign ge   = (t >= {1'b0, d_in});
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        lo_q[k] <= {lo_in[QW-2:0], 1'b0};
        qt_q[k] <= {q_in[QW-2:0], ge};
        d_q[k]  <= d_in;
        s_q[k]  <= s_in;
      end
    end
  end

  assign vld_o  = v_q[QW-1];
  assign quo_o  = qt_q[QW-1];
  assign side_o = s_q[QW-1];

endmodule

### design/ffr_back.sv
`timescale 1ns / 1ps

module ffr_back #(
  parameter int unsigned MAX_BANDS   = ffr_pkg::MAX_BANDS_DEF,
  parameter int unsigned MAX_COLUMNS = ffr_pkg::MAX_COLUMNS_DEF,
  localparam int unsigned DEPTH = MAX_BANDS * MAX_COLUMNS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned EW = AW + $bits(ffr_pkg::item_t)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fifo_valid_i,
  input  logic [EW-1:0]                 fifo_data_i,
  output logic                          pop_o,
  output logic                          busy_o,
  input  ffr_pkg::lines_t               lines_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffr_pkg::REFL_W-1:0]    refl_o,
  output logic                          zero_span_o,
  output logic                          saturated_o
);

  localparam int unsigned SUM_W = ffr_pkg::SUM_W;
  localparam int unsigned AVG_W = ffr_pkg::AVG_W;
  localparam int unsigned LW    = ffr_pkg::LINES_W;
  localparam int unsigned XW    = ffr_pkg::SAMPLE_W;
  localparam int unsigned NW    = AVG_W + 2;
  localparam int unsigned MW    = AVG_W + 1;

  logic adv;

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // front of pipe
  ffr_pkg::item_t head_item;
  logic [AW-1:0]  head_idx;

  // lookup stage
  logic           s1_v_q;
  ffr_pkg::item_t s1_item_q;
  logic [AW-1:0]  s1_idx_q;
  logic [SUM_W-1:0] w_rd, d_rd, w_cur, d_cur;
  logic [SUM_W:0]   w_add, d_add;
  logic [SUM_W-1:0] w_new, d_new;
  logic             w_we, d_we, s1_img, s1_zs;

  logic             lw_w_v_q, lw_d_v_q;
  logic [AW-1:0]    lw_w_addr_q, lw_d_addr_q;
  logic [SUM_W-1:0] lw_w_data_q, lw_d_data_q;

  logic             ram_we_w, ram_we_d;
  logic [AW-1:0]    ram_waddr_w, ram_waddr_d;
  logic [SUM_W-1:0] ram_wdata_w, ram_wdata_d;

  // average dividers
  logic             w_ovf, d_ovf;
  logic             wdiv_v, ddiv_v;
  logic [AVG_W-1:0] wdiv_q, ddiv_q;
  logic [XW+1:0]    wdiv_side;
  logic [0:0]       ddiv_side;

  // span stages
  logic             s2_v_q, s2_zs_q;
  logic [AVG_W-1:0] s2_wa_q, s2_da_q;
  logic [XW-1:0]    s2_x_q;
  logic             s3_v_q, s3_zs_q;
  logic signed [NW-1:0] s3_num_q, s3_den_q;
  logic             s4_v_q, s4_zs_q, s4_neg_q;
  logic [MW-1:0]    s4_mn_q, s4_md_q;
  logic [MW-1:0]    q_rem;
  logic             q_ovf;

  // quotient divider
  logic             qdiv_v;
  logic [AVG_W-1:0] qdiv_q;
  logic [2:0]       qdiv_side;

  // result
  logic                       out_v_q;
  logic [ffr_pkg::REFL_W-1:0] refl_q;
  logic                       zs_q, sat_q;
  logic                       f_neg, f_zs, f_ovf, f_sat;
  logic [ffr_pkg::REFL_W-1:0] f_refl;

  assign adv    = !out_v_q || out_ready_i;
  assign busy_o = clr_q;
  assign pop_o  = adv && fifo_valid_i && !clr_q;
  assign {head_idx, head_item} = fifo_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(DEPTH-1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign ram_we_w    = clr_q || w_we;
  assign ram_waddr_w = clr_q ? clr_addr_q : s1_idx_q;
  assign ram_wdata_w = clr_q ? '0 : w_new;
  assign ram_we_d    = clr_q || d_we;
  assign ram_waddr_d = clr_q ? clr_addr_q : s1_idx_q;
  assign ram_wdata_d = clr_q ? '0 : d_new;

  ffr_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_white_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_w),
    .waddr_i (ram_waddr_w),
    .wdata_i (ram_wdata_w),
    .re_i    (adv),
    .raddr_i (head_idx),
    .rdata_o (w_rd)
  );

  ffr_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_dark_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_d),
    .waddr_i (ram_waddr_d),
    .wdata_i (ram_wdata_d),
    .re_i    (adv),
    .raddr_i (head_idx),
    .rdata_o (d_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q <= head_item;
      s1_idx_q  <= head_idx;
    end
  end

  // latest write wins over a read issued in the same cycle
  assign w_cur = (lw_w_v_q && lw_w_addr_q == s1_idx_q) ? lw_w_data_q : w_rd;
  assign d_cur = (lw_d_v_q && lw_d_addr_q == s1_idx_q) ? lw_d_data_q : d_rd;
  assign w_add = {1'b0, w_cur} + (SUM_W+1)'(s1_item_q.sample);
  assign d_add = {1'b0, d_cur} + (SUM_W+1)'(s1_item_q.sample);
  assign w_new = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
  assign d_new = d_add[SUM_W] ? '1 : d_add[SUM_W-1:0];
  assign w_we  = adv && s1_v_q && s1_item_q.ok && (s1_item_q.kind == ffr_pkg::ACT_WHITE);
  assign d_we  = adv && s1_v_q && s1_item_q.ok && (s1_item_q.kind == ffr_pkg::ACT_DARK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_w_v_q <= 1'b0;
      lw_d_v_q <= 1'b0;
    end else begin
      if (w_we) begin
        lw_w_v_q <= 1'b1;
      end
      if (d_we) begin
        lw_d_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      lw_w_addr_q <= s1_idx_q;
      lw_w_data_q <= w_new;
    end
    if (d_we) begin
      lw_d_addr_q <= s1_idx_q;
      lw_d_data_q <= d_new;
    end
  end

  assign s1_img = s1_v_q && (s1_item_q.kind == ffr_pkg::ACT_IMAGE);
  assign s1_zs  = !s1_item_q.ok || (lines_i.white == '0) || (lines_i.dark == '0);
  assign w_ovf  = (LW'(w_cur[SUM_W-1:16]) >= lines_i.white);
  assign d_ovf  = (LW'(d_cur[SUM_W-1:16]) >= lines_i.dark);

  ffr_div #(.DW(LW), .QW(AVG_W), .SW(XW+2)) u_white_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_img),
    .rem_i  (LW'(w_cur[SUM_W-1:16])),
    .low_i  ({w_cur[15:0], 8'd0}),
    .den_i  (lines_i.white),
    .side_i ({s1_item_q.sample, s1_zs, w_ovf}),
    .vld_o  (wdiv_v),
    .quo_o  (wdiv_q),
    .side_o (wdiv_side)
  );

  ffr_div #(.DW(LW), .QW(AVG_W), .SW(1)) u_dark_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_img),
    .rem_i  (LW'(d_cur[SUM_W-1:16])),
    .low_i  ({d_cur[15:0], 8'd0}),
    .den_i  (lines_i.dark),
    .side_i (d_ovf),
    .vld_o  (ddiv_v),
    .quo_o  (ddiv_q),
    .side_o (ddiv_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= wdiv_v && ddiv_v;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_wa_q  <= wdiv_side[0] ? '1 : wdiv_q;
      s2_da_q  <= ddiv_side[0] ? '1 : ddiv_q;
      s2_x_q   <= wdiv_side[XW+1:2];
      s2_zs_q  <= wdiv_side[1];

      s3_num_q <= $signed({2'b00, s2_x_q, 8'd0}) - $signed({2'b00, s2_da_q});
      s3_den_q <= $signed({2'b00, s2_wa_q}) - $signed({2'b00, s2_da_q});
      s3_zs_q  <= s2_zs_q;

      s4_neg_q <= s3_num_q[NW-1] ^ s3_den_q[NW-1];
      s4_mn_q  <= s3_num_q[NW-1] ? MW'(-s3_num_q) : MW'(s3_num_q);
      s4_md_q  <= s3_den_q[NW-1] ? MW'(-s3_den_q) : MW'(s3_den_q);
      s4_zs_q  <= s3_zs_q || (s3_den_q == '0);
    end
  end

  assign q_rem = MW'(s4_mn_q[MW-1:8]);
  assign q_ovf = (q_rem >= s4_md_q);

  ffr_div #(.DW(MW), .QW(AVG_W), .SW(3)) u_quot_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s4_v_q),
    .rem_i  (q_rem),
    .low_i  ({s4_mn_q[7:0], 16'd0}),
    .den_i  (s4_md_q),
    .side_i ({s4_neg_q, s4_zs_q, q_ovf}),
    .vld_o  (qdiv_v),
    .quo_o  (qdiv_q),
    .side_o (qdiv_side)
  );

  assign {f_neg, f_zs, f_ovf} = qdiv_side;

  always_comb begin
    f_sat  = 1'b0;
    f_refl = '0;
    if (!f_zs) begin
      if (f_neg) begin
        f_sat  = f_ovf || (qdiv_q > 24'h800000);
        f_refl = f_sat ? 24'h800000 : -qdiv_q;
      end else begin
        f_sat  = f_ovf || qdiv_q[AVG_W-1];
        f_refl = f_sat ? 24'h7FFFFF : qdiv_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= qdiv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      refl_q <= f_refl;
      zs_q   <= f_zs;
      sat_q  <= f_sat;
    end
  end

  assign out_valid_o = out_v_q;
  assign refl_o      = refl_q;
  assign zero_span_o = zs_q;
  assign saturated_o = sat_q;

endmodule

### design/flat_field_reflectance.sv
`timescale 1ns / 1ps
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: band, column, sample
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: reflectance; tuser: zero_span, saturated
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// one beat per cycle sustained while m_axis is not stalled; an image beat's result passes the lookup stage,
// the two 24-step divider pipelines (averages, then quotient) with the span stages between, and an output register
// after reset a clearing pass over all MAX_BANDS*MAX_COLUMNS cells zeroes the sum memories;
// s_axis_tready stays low meanwhile, config writes are taken throughout
// a stalled m_axis holds the whole back pipe; a 4-entry queue keeps s_axis taking beats until it fills

module flat_field_reflectance #(
  parameter int unsigned MAX_BANDS     = ffr_pkg::MAX_BANDS_DEF,
  parameter int unsigned MAX_COLUMNS   = ffr_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_REF_LINES = ffr_pkg::MAX_REF_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // band, column, sample, zero pad
  input  logic [1:0]                    s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // reflectance
  output logic [1:0]                    m_axis_tuser,  // zero_span, saturated
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffr_pkg::LINES_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = MAX_BANDS * MAX_COLUMNS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = AW + $bits(ffr_pkg::item_t);

  logic            busy, fifo_full, push, pop, fifo_valid;
  logic [EW-1:0]   push_data, fifo_data;
  ffr_pkg::lines_t lines;
  logic            zero_span, saturated;

  ffr_front #(
    .MAX_BANDS     (MAX_BANDS),
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_REF_LINES (MAX_REF_LINES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .band_i      (s_axis_tdata[7:0]),
    .column_i    (s_axis_tdata[17:8]),
    .sample_i    (s_axis_tdata[33:18]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_i      (busy),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data),
    .lines_o     (lines)
  );

  ffr_fifo #(.WIDTH(EW), .DEPTH(ffr_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_data)
  );

  ffr_back #(
    .MAX_BANDS   (MAX_BANDS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .busy_o       (busy),
    .lines_i      (lines),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .refl_o       (m_axis_tdata),
    .zero_span_o  (zero_span),
    .saturated_o  (saturated)
  );

  assign m_axis_tuser = {saturated, zero_span};

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CELLS = ffr_pkg::MAX_BANDS_DEF * ffr_pkg::MAX_COLUMNS_DEF;
  localparam logic [ffr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = ffr_pkg::CFG_DARK_LINES + 8'd1;
  localparam int unsigned SETTLE = 100;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [ffr_pkg::SUM_W-1:0] SUM_FULL = '1;
  localparam longint AVG_FULL = 64'hFFFFFF;

  typedef struct packed {
    logic signed [ffr_pkg::REFL_W-1:0] refl;
    logic zero_span;
    logic saturated;
  } refl_t;

  typedef struct {
    ffr_pkg::action_e act;
    logic [ffr_pkg::BAND_W-1:0] band;
    logic [ffr_pkg::COLUMN_W-1:0] column;
    logic [ffr_pkg::SAMPLE_W-1:0] sample;
    bit typed;
    refl_t res;
  } beat_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i, cfg_ready_o;
  logic [ffr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [ffr_pkg::LINES_W-1:0] cfg_data_i;

  flat_field_reflectance dut (.*);

  bit [ffr_pkg::SUM_W-1:0] white_acc [CELLS];
  bit [ffr_pkg::SUM_W-1:0] dark_acc [CELLS];
  logic [ffr_pkg::LINES_W-1:0] white_lines_m = ffr_pkg::LINES_W'(1);
  logic [ffr_pkg::LINES_W-1:0] dark_lines_m = ffr_pkg::LINES_W'(1);
  refl_t pending [$];
  int unsigned mismatches = 0;
  bit quiet = 0;
  longint cycles = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(string what, refl_t got, refl_t want);
    $display("mismatch %s: got refl %0d zs %0b sat %0b, want refl %0d zs %0b sat %0b",
             what, got.refl, got.zero_span, got.saturated,
             want.refl, want.zero_span, want.saturated);
    mismatches++;
  endtask

  function automatic longint average(longint sum, longint lines);
    longint a;
    a = (sum * 256) / lines;
    return a > AVG_FULL ? AVG_FULL : a;
  endfunction

  function automatic refl_t calibrate(int unsigned slot, logic [ffr_pkg::SAMPLE_W-1:0] x);
    longint wl, dl, wa, da, den, num, q;
    refl_t r;
    r = '{refl: '0, zero_span: 1'b1, saturated: 1'b0};
    wl = white_lines_m > ffr_pkg::MAX_REF_LINES_DEF ? ffr_pkg::MAX_REF_LINES_DEF
                                                    : white_lines_m;
    dl = dark_lines_m > ffr_pkg::MAX_REF_LINES_DEF ? ffr_pkg::MAX_REF_LINES_DEF
                                                   : dark_lines_m;
    if (wl == 0 || dl == 0) return r;
    wa = average(white_acc[slot], wl);
    da = average(dark_acc[slot], dl);
    den = wa - da;
    if (den == 0) return r;
    num = longint'(x) * 256 - da;
    q = (num * 65536) / den;
    r.zero_span = 1'b0;
    if (q > 8388607) begin
      q = 8388607;
      r.saturated = 1'b1;
    end else if (q < -8388608) begin
      q = -8388608;
      r.saturated = 1'b1;
    end
    r.refl = q[ffr_pkg::REFL_W-1:0];
    return r;
  endfunction

  function automatic bit [ffr_pkg::SUM_W-1:0] add_sat(bit [ffr_pkg::SUM_W-1:0] s,
                                                     logic [ffr_pkg::SAMPLE_W-1:0] x);
    longint t;
    t = longint'(s) + longint'(x);
    return t > SUM_FULL ? SUM_FULL : t[ffr_pkg::SUM_W-1:0];
  endfunction

  task automatic send(beat_t b);
    int unsigned slot;
    slot = 32'({b.band, b.column});
    while (!quiet && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= b.act;
    s_axis_tdata <= {6'd0, b.sample, b.column, b.band};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (b.act)
      ffr_pkg::ACT_WHITE: white_acc[slot] = add_sat(white_acc[slot], b.sample);
      ffr_pkg::ACT_DARK:  dark_acc[slot] = add_sat(dark_acc[slot], b.sample);
      ffr_pkg::ACT_IMAGE: pending.push_back(b.typed ? b.res : calibrate(slot, b.sample));
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ffr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ffr_pkg::LINES_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == ffr_pkg::CFG_WHITE_LINES) white_lines_m = val;
    else if (idx == ffr_pkg::CFG_DARK_LINES) dark_lines_m = val;
  endtask

  function automatic logic [ffr_pkg::LINES_W-1:0] pick_lines();
    case ($urandom_range(4))
      0: return '0;
      1: return 10'd1;
      2: return 10'd1023;
      default: return ffr_pkg::LINES_W'($urandom_range(1023));
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || $urandom_range(99) >= 28;
  end

  always @(posedge clk_i) begin
    refl_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{refl: m_axis_tdata, zero_span: m_axis_tuser[0], saturated: m_axis_tuser[1]};
      if (pending.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        want = pending.pop_front();
        if (got.refl !== want.refl) report("reflectance", got, want);
        else if (got.zero_span !== want.zero_span) report("zero_span", got, want);
        else if (got.saturated !== want.saturated) report("saturated", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  beat_t directed [] = '{
    '{ffr_pkg::ACT_IMAGE, 8'd0, 10'd0, 16'd0, 1, '{'0, 1'b1, 1'b0}},
    '{ffr_pkg::ACT_IMAGE, 8'd255, 10'd1023, 16'hFFFF, 1, '{'0, 1'b1, 1'b0}},
    '{ffr_pkg::ACT_WHITE, 8'd3, 10'd5, 16'hFFFF, 0, '0},
    '{ffr_pkg::ACT_DARK, 8'd3, 10'd5, 16'd0, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd3, 10'd5, 16'hFFFF, 1, '{24'sd65536, 1'b0, 1'b0}},
    '{ffr_pkg::ACT_IMAGE, 8'd3, 10'd5, 16'd0, 1, '{'0, 1'b0, 1'b0}},
    '{ffr_pkg::ACT_IMAGE, 8'd3, 10'd5, 16'd32768, 0, '0},
    '{ffr_pkg::ACT_NONE, 8'd3, 10'd5, 16'hFFFF, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd3, 10'd5, 16'd1000, 0, '0},
    '{ffr_pkg::ACT_WHITE, 8'd7, 10'd7, 16'd1, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd7, 10'd7, 16'hFFFF, 1, '{24'sd8388607, 1'b0, 1'b1}},
    '{ffr_pkg::ACT_DARK, 8'd8, 10'd8, 16'd1, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd8, 10'd8, 16'hFFFF, 1, '{-24'sd8388608, 1'b0, 1'b1}},
    '{ffr_pkg::ACT_DARK, 8'd4, 10'd4, 16'd5000, 0, '0},
    '{ffr_pkg::ACT_WHITE, 8'd4, 10'd4, 16'd2000, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd4, 10'd4, 16'd100, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd4, 10'd4, 16'd9000, 0, '0},
    '{ffr_pkg::ACT_WHITE, 8'd255, 10'd1023, 16'd40000, 0, '0},
    '{ffr_pkg::ACT_DARK, 8'd255, 10'd1023, 16'd40000, 0, '0},
    '{ffr_pkg::ACT_IMAGE, 8'd255, 10'd1023, 16'd40000, 1, '{'0, 1'b1, 1'b0}}
  };

  initial begin
    beat_t b;
    logic [ffr_pkg::BAND_W-1:0] pool_band [6];
    logic [ffr_pkg::COLUMN_W-1:0] pool_col [6];
    int unsigned k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ffr_pkg::ACT_NONE;
    cfg_valid_i = 1'b0;
    cfg_index_i = ffr_pkg::CFG_WHITE_LINES;
    cfg_data_i = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send(directed[i]);
    drain();

    write_reg(ffr_pkg::CFG_WHITE_LINES, 10'd1023);
    write_reg(ffr_pkg::CFG_DARK_LINES, 10'd2);
    write_reg(CFG_UNUSED, 10'd0);
    for (int i = 0; i < 20; i++) begin
      send('{ffr_pkg::ACT_WHITE, 8'd9, 10'd9, 16'hFFFF, 0, '0});
      send('{ffr_pkg::ACT_DARK, 8'd10, 10'd10, 16'hFFFF, 0, '0});
    end
    send('{ffr_pkg::ACT_IMAGE, 8'd9, 10'd9, 16'd12345, 0, '0});
    send('{ffr_pkg::ACT_IMAGE, 8'd10, 10'd10, 16'hFFFF, 0, '0});
    drain();
    write_reg(ffr_pkg::CFG_WHITE_LINES, 10'd0);
    send('{ffr_pkg::ACT_IMAGE, 8'd9, 10'd9, 16'd1, 0, '0});
    drain();
    write_reg(ffr_pkg::CFG_WHITE_LINES, 10'd1);
    write_reg(ffr_pkg::CFG_DARK_LINES, 10'd0);
    send('{ffr_pkg::ACT_IMAGE, 8'd4, 10'd4, 16'd1, 0, '0});
    drain();
    write_reg(ffr_pkg::CFG_DARK_LINES, 10'd1);

    for (int i = 0; i < 6; i++) begin
      pool_band[i] = ffr_pkg::BAND_W'($urandom_range(255));
      pool_col[i] = ffr_pkg::COLUMN_W'($urandom_range(1023));
    end
    for (int n = 0; n < 640; n++) begin
      if (n % 140 == 139) begin
        drain();
        write_reg(ffr_pkg::CFG_WHITE_LINES, pick_lines());
        write_reg(ffr_pkg::CFG_DARK_LINES, pick_lines());
      end
      if (n == 350) drain();
      quiet = n >= 230 && n < 330;
      k = $urandom_range(99);
      b.act = k < 35 ? ffr_pkg::ACT_WHITE : k < 65 ? ffr_pkg::ACT_DARK :
              k < 95 ? ffr_pkg::ACT_IMAGE : ffr_pkg::ACT_NONE;
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(5);
        b.band = pool_band[k];
        b.column = pool_col[k];
      end else begin
        b.band = ffr_pkg::BAND_W'($urandom);
        b.column = ffr_pkg::COLUMN_W'($urandom);
      end
      b.sample = ffr_pkg::SAMPLE_W'((b.act == ffr_pkg::ACT_DARK && $urandom_range(1))
                                    ? $urandom_range(4000) : $urandom);
      b.typed = 0;
      b.res = '0;
      send(b);
    end
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
